[rtl/gcs_pkg.sv]
// Shared constants and elaboration-time tables for the great-circle speed pipeline.
// Holds the Q60 angle constants, the CORDIC arctangent table and gain compensation.
// No dependencies.
package gcs_pkg;

  localparam int FRAC_BITS         = 60;
  localparam int CORDIC_STAGES_DEF = 32;
  localparam int CORDIC_MAX        = 48;
  localparam int MULQ_LAT          = 4;
  localparam int SQ_BITS           = 61;
  localparam int DIV_BITS          = 36;
  localparam int SECS_W            = 32;

  localparam logic [63:0] ONE_Q60   = 64'd1 << FRAC_BITS;
  localparam logic [32:0] RADIUS_MM = 33'd6372000000;
  localparam logic [34:0] SPEED_MAX = 35'd20018760000;

  // restoring quotient of n by d, evaluated only while building constants
  function automatic logic [127:0] gcs_udiv(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q;
    logic [128:0] r;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[127:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q62 by its Taylor series
  function automatic logic [63:0] gcs_atan_recip(input logic [63:0] n);
    logic [63:0] one;
    logic [63:0] nn;
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] t;
    logic        done;
    one  = 64'd1 << 62;
    nn   = n * n;
    p    = n;
    sum  = '0;
    k    = '0;
    done = 1'b0;
    for (int it = 0; it < 64; it++) begin
      if (!done) begin
        t = 64'(gcs_udiv({64'd0, one}, {64'd0, p}));
        t = 64'(gcs_udiv({64'd0, t}, {64'd0, 64'd2 * k + 64'd1}));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        if (p > 64'(gcs_udiv({64'd0, one}, {64'd0, nn}))) done = 1'b1;
        else begin
          p = p * nn;
          k = k + 64'd1;
        end
      end
    end
    return sum;
  endfunction

  // pi in Q62 by Machin's formula
  localparam logic [63:0] PI62 = 64'(64'd16 * gcs_atan_recip(64'd5)
                                     - 64'd4 * gcs_atan_recip(64'd239));
  localparam logic [63:0] PI_Q60      = PI62 >> 2;
  localparam logic [63:0] HALF_PI_Q60 = PI62 >> 3;

  // degree scale: pi * 2^92 / 1.8e9, truncated
  function automatic logic [63:0] gcs_deg_scale();
    logic [127:0] num;
    num = {64'd0, PI62} << 30;
    return 64'(gcs_udiv(num, 128'd1800000000));
  endfunction

  localparam logic [63:0] DEG_SCALE = gcs_deg_scale();
  localparam logic [31:0] DS_LO     = DEG_SCALE[31:0];
  localparam logic [30:0] DS_HI     = DEG_SCALE[62:32];

  // arctangent table entry for CORDIC step i, Q60
  function automatic logic [63:0] gcs_atan(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    int          sh;
    sum = '0;
    if (i == 0) sum = PI62 >> 4;
    else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= FRAC_BITS) begin
          sh = FRAC_BITS - i * (2 * k + 1);
          t  = 64'(gcs_udiv({64'd0, 64'd1 << sh}, 128'(2 * k + 1)));
          if (k[0]) sum = sum - t;
          else sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

  // CORDIC gain of a rotation of one with zero angle
  function automatic logic [63:0] gcs_gain(input int stages);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] xn;
    logic [63:0] yn;
    x = ONE_Q60;
    y = '0;
    z = '0;
    for (int i = 0; i < CORDIC_MAX; i++) begin
      if (i < stages) begin
        if (z[63]) begin
          xn = x + 64'($signed(y) >>> i);
          yn = y - 64'($signed(x) >>> i);
          z  = z + gcs_atan(i);
        end else begin
          xn = x - 64'($signed(y) >>> i);
          yn = y + 64'($signed(x) >>> i);
          z  = z - gcs_atan(i);
        end
        x = xn;
        y = yn;
      end
    end
    return x;
  endfunction

  // gain compensation: 2^120 / gain
  function automatic logic [63:0] gcs_kinv(input int stages);
    logic [127:0] num;
    num = 128'd1 << 120;
    return 64'(gcs_udiv(num, {64'd0, gcs_gain(stages)}));
  endfunction

endpackage

[rtl/great_circle_speed.sv]
// Throughput: one word per cycle while the output queue is not full; the CORDIC, square-root
// and divider pipelines each take one step per register stage, and a two-entry output
// queue absorbs a waiting result.
// Reset: synchronous rst clears the valid bits and the output queue; data regs are not reset.
// Top level: haversine distance between two fixes divided by their time interval.
module great_circle_speed import gcs_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fix_valid,
  output logic        fix_stall,
  input  logic [30:0] start_lat,
  input  logic [31:0] start_lon,
  input  logic [31:0] start_time,
  input  logic [30:0] end_lat,
  input  logic [31:0] end_lon,
  input  logic [31:0] end_time,
  output logic        speed_valid,
  input  logic        speed_stall,
  output logic [34:0] speed_mm_s,
  output logic        zero_interval
);

  localparam int S         = CORDIC_STAGES;
  localparam logic [63:0] KINV = gcs_kinv(S);
  localparam int ST_UNFLIP = 6 + S;
  localparam int ST_MQ2    = ST_UNFLIP + 2 * MULQ_LAT;
  localparam int ST_CMPL   = ST_MQ2 + 3;
  localparam int ST_SQRT   = ST_CMPL + SQ_BITS;
  localparam int ST_ATAN   = ST_SQRT + S;
  localparam int ST_D28    = ST_ATAN + 3;
  localparam int ST_NUM    = ST_D28 + 1;
  localparam int P         = ST_NUM + DIV_BITS;

  logic         advance;
  logic [P:0]   vld;

  // stage 0: input word
  logic [30:0]  lat1_r;
  logic [31:0]  lon1_r;
  logic [31:0]  t1_r;
  logic [30:0]  lat2_r;
  logic [31:0]  lon2_r;
  logic [31:0]  t2_r;

  // stage 1..5: angle conversion and fold
  logic [32:0]  ang  [0:3];
  logic [31:0]  m1   [0:3];
  logic [3:0]   neg1;
  logic [63:0]  pl2  [0:3];
  logic [62:0]  ph2  [0:3];
  logic [3:0]   neg2;
  logic [94:0]  rsum [0:3];
  logic [63:0]  r3   [0:3];
  logic [3:0]   neg3;
  logic [63:0]  th4  [0:3];
  logic [63:0]  z5   [0:3];
  logic [3:0]   flip5;
  logic [3:0]   flip_d [1:S];
  logic [63:0]  cx   [0:3];
  logic [63:0]  cy   [0:3];

  // haversine term
  logic [63:0]  s_lat;
  logic [63:0]  s_lon;
  logic [63:0]  c_lat1;
  logic [63:0]  c_lat2;
  logic [63:0]  sq1;
  logic [63:0]  cc;
  logic [63:0]  sq2;
  logic [63:0]  m2;
  logic [63:0]  sq1_d [1:MULQ_LAT];
  logic [63:0]  a_sum;
  logic [SQ_BITS-1:0] a_cl;
  logic [SQ_BITS-1:0] a_v;
  logic [SQ_BITS-1:0] b_v;
  logic [SQ_BITS-1:0] rt_a;
  logic [SQ_BITS-1:0] rt_b;
  logic [63:0]  zv;

  // distance and speed
  logic [61:0]  z2;
  logic [64:0]  rl;
  logic [62:0]  rh;
  logic [94:0]  prod;
  logic [62:0]  d28;
  logic [63:0]  nsum;
  logic [DIV_BITS-1:0] numq;
  logic [DIV_BITS-1:0] quo;
  logic [SECS_W-1:0]   secs_d [1:ST_NUM];
  logic                zero_d [1:P];
  logic [34:0]  sp;

  // output queue
  logic [1:0]   cnt;
  logic [34:0]  q0_speed;
  logic         q0_zero;
  logic [34:0]  q1_speed;
  logic         q1_zero;
  logic         push;
  logic         pop;

  // move the whole pipeline while the queue has room
  assign advance   = (cnt != 2'd2);
  assign fix_stall = ~advance;

  // carry valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[P-1:0], fix_valid};
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (advance) begin
      lat1_r <= start_lat;
      lon1_r <= start_lon;
      t1_r   <= start_time;
      lat2_r <= end_lat;
      lon2_r <= end_lon;
      t2_r   <= end_time;
    end
  end

  // angle differences and whole latitudes, as 33-bit signed
  always_comb begin
    ang[0] = {{2{lat1_r[30]}}, lat1_r} - {{2{lat2_r[30]}}, lat2_r};
    ang[1] = {lon1_r[31], lon1_r} - {lon2_r[31], lon2_r};
    ang[2] = {{2{lat1_r[30]}}, lat1_r};
    ang[3] = {{2{lat2_r[30]}}, lat2_r};
  end

  // wide sum of the degree-scale partial products
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rsum[j] = {ph2[j], 32'd0} + 95'(pl2[j]);
    end
  end

  // convert to Q60 radians, half angle for the differences
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < 4; j++) begin
        m1[j]   <= ang[j][32] ? 32'(33'd0 - ang[j]) : ang[j][31:0];
        neg1[j] <= ang[j][32];
        pl2[j]  <= 64'(m1[j]) * 64'(DS_LO);
        ph2[j]  <= 63'(m1[j]) * 63'(DS_HI);
        if (j < 2) r3[j] <= 64'(rsum[j][94:33]);
        else r3[j] <= 64'(rsum[j][94:32]);
        th4[j]  <= neg3[j] ? 64'd0 - r3[j] : r3[j];
        // fold into [-pi/2, pi/2]
        if ($signed(th4[j]) > $signed(HALF_PI_Q60)) begin
          z5[j]    <= th4[j] - PI_Q60;
          flip5[j] <= 1'b1;
        end else if ($signed(64'd0 - HALF_PI_Q60) > $signed(th4[j])) begin
          z5[j]    <= th4[j] + PI_Q60;
          flip5[j] <= 1'b1;
        end else begin
          z5[j]    <= th4[j];
          flip5[j] <= 1'b0;
        end
      end
      neg2 <= neg1;
      neg3 <= neg2;
    end
  end

  // sine and cosine units
  for (genvar j = 0; j < 4; j++) begin : g_sincos
    gcs_cordic #(.STAGES(S), .VECTOR(1'b0)) u_rot (
      .clk   (clk),
      .en    (advance),
      .x_in  (KINV),
      .y_in  (64'd0),
      .z_in  (z5[j]),
      .x_out (cx[j]),
      .y_out (cy[j]),
      .z_out ()
    );
  end

  // hold the fold flags across the CORDIC, then undo the fold
  always_ff @(posedge clk) begin
    if (advance) begin
      flip_d[1] <= flip5;
      for (int k = 2; k <= S; k++) flip_d[k] <= flip_d[k-1];
      s_lat  <= flip_d[S][0] ? 64'd0 - cy[0] : cy[0];
      s_lon  <= flip_d[S][1] ? 64'd0 - cy[1] : cy[1];
      c_lat1 <= flip_d[S][2] ? 64'd0 - cx[2] : cx[2];
      c_lat2 <= flip_d[S][3] ? 64'd0 - cx[3] : cx[3];
    end
  end

  gcs_mulq u_mq_slat (.clk(clk), .en(advance), .a(s_lat),  .b(s_lat),  .p(sq1));
  gcs_mulq u_mq_cc   (.clk(clk), .en(advance), .a(c_lat1), .b(c_lat2), .p(cc));
  gcs_mulq u_mq_slon (.clk(clk), .en(advance), .a(s_lon),  .b(s_lon),  .p(sq2));
  gcs_mulq u_mq_prod (.clk(clk), .en(advance), .a(cc),     .b(sq2),    .p(m2));

  // add the two terms, clamp to [0, 1] and form 1 - a
  always_ff @(posedge clk) begin
    if (advance) begin
      sq1_d[1] <= sq1;
      for (int k = 2; k <= MULQ_LAT; k++) sq1_d[k] <= sq1_d[k-1];
      a_sum <= sq1_d[MULQ_LAT] + m2;
      if (a_sum[63]) a_cl <= '0;
      else if (a_sum > ONE_Q60) a_cl <= SQ_BITS'(ONE_Q60);
      else a_cl <= a_sum[SQ_BITS-1:0];
      a_v <= a_cl;
      b_v <= SQ_BITS'(ONE_Q60) - a_cl;
    end
  end

  gcs_isqrt u_sqrt_a (.clk(clk), .en(advance), .v(a_v), .root(rt_a));
  gcs_isqrt u_sqrt_b (.clk(clk), .en(advance), .v(b_v), .root(rt_b));

  // central half angle
  gcs_cordic #(.STAGES(S), .VECTOR(1'b1)) u_atan (
    .clk   (clk),
    .en    (advance),
    .x_in  (64'(rt_b)),
    .y_in  (64'(rt_a)),
    .z_in  (64'd0),
    .x_out (),
    .y_out (),
    .z_out (zv)
  );

  assign prod = {rh, 32'd0} + 95'(rl);
  assign nsum = 64'(d28) + 64'({secs_d[ST_D28], 27'd0});

  // distance in mm with 28 fraction bits, then add half the interval for rounding
  always_ff @(posedge clk) begin
    if (advance) begin
      z2   <= zv[63] ? 62'd0 : {zv[60:0], 1'b0};
      rl   <= 65'(RADIUS_MM) * 65'(z2[31:0]);
      rh   <= 63'(RADIUS_MM) * 63'(z2[61:32]);
      d28  <= prod[94:32];
      numq <= nsum[63:28];
    end
  end

  // interval and its zero flag ride alongside
  always_ff @(posedge clk) begin
    if (advance) begin
      secs_d[1] <= (t1_r > t2_r) ? t1_r - t2_r : t2_r - t1_r;
      zero_d[1] <= (t1_r == t2_r);
      for (int k = 2; k <= ST_NUM; k++) secs_d[k] <= secs_d[k-1];
      for (int k = 2; k <= P; k++) zero_d[k] <= zero_d[k-1];
    end
  end

  gcs_div u_div (
    .clk (clk),
    .en  (advance),
    .num (numq),
    .den (secs_d[ST_NUM]),
    .quo (quo)
  );

  // saturate, and drop the speed for a zero interval
  always_comb begin
    if (zero_d[P]) sp = '0;
    else if (quo > DIV_BITS'(SPEED_MAX)) sp = SPEED_MAX;
    else sp = quo[34:0];
  end

  assign push = advance & vld[P];
  assign pop  = speed_valid & ~speed_stall;

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // write the head from the pipeline when the queue empties, else shift the tail up
  always_ff @(posedge clk) begin
    if (push && ((cnt - 2'(pop)) == 2'd0)) begin
      q0_speed <= sp;
      q0_zero  <= zero_d[P];
    end else if (pop) begin
      q0_speed <= q1_speed;
      q0_zero  <= q1_zero;
    end
    if (push && ((cnt - 2'(pop)) != 2'd0)) begin
      q1_speed <= sp;
      q1_zero  <= zero_d[P];
    end
  end

  assign speed_valid   = (cnt != 2'd0);
  assign speed_mm_s    = q0_speed;
  assign zero_interval = q0_zero;

  // a held pipeline keeps its last word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[P] && !advance) |=> vld[P])
    else $error("last pipeline word lost while held");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (speed_valid && zero_interval) |-> (speed_mm_s == 35'd0))
    else $error("nonzero speed with zero interval");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    speed_valid |-> (speed_mm_s <= SPEED_MAX))
    else $error("speed above saturation limit");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !push)
    else $error("push into a full output queue");

endmodule

[rtl/gcs_cordic.sv]
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on gcs_pkg for the arctangent table.
module gcs_cordic import gcs_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x_in,
  input  logic [63:0] y_in,
  input  logic [63:0] z_in,
  output logic [63:0] x_out,
  output logic [63:0] y_out,
  output logic [63:0] z_out
);

  logic [63:0] xr [1:STAGES];
  logic [63:0] yr [1:STAGES];
  logic [63:0] zr [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [63:0] ANG = gcs_atan(i);
    logic [63:0] xi;
    logic [63:0] yi;
    logic [63:0] zi;
    logic [63:0] xsh;
    logic [63:0] ysh;
    logic        dir;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xr[i];
      assign yi = yr[i];
      assign zi = zr[i];
    end

    assign xsh = 64'($signed(xi) >>> i);
    assign ysh = 64'($signed(yi) >>> i);
    // steer on the angle residue, or on the sign of y when vectoring
    assign dir = VECTOR ? ~yi[63] : zi[63];

    // advance one micro-rotation
    always_ff @(posedge clk) begin
      if (en) begin
        if (dir) begin
          xr[i+1] <= xi + ysh;
          yr[i+1] <= yi - xsh;
          zr[i+1] <= zi + ANG;
        end else begin
          xr[i+1] <= xi - ysh;
          yr[i+1] <= yi + xsh;
          zr[i+1] <= zi - ANG;
        end
      end
    end
  end

  assign x_out = xr[STAGES];
  assign y_out = yr[STAGES];
  assign z_out = zr[STAGES];

endmodule

[rtl/gcs_mulq.sv]
// Signed Q60 product, truncated toward zero, over four register stages.
// Depends on gcs_pkg for the fraction width.
module gcs_mulq import gcs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg1;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg2;
  logic [63:0]  pr;
  logic         neg3;
  logic [127:0] full;

  assign full = {p11, 64'd0} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {64'd0, p00};

  always_ff @(posedge clk) begin
    if (en) begin
      // take magnitudes
      ua   <= a[63] ? 64'd0 - a : a;
      ub   <= b[63] ? 64'd0 - b : b;
      neg1 <= a[63] ^ b[63];
      // form partial products
      p00  <= 64'(ua[31:0])  * 64'(ub[31:0]);
      p01  <= 64'(ua[31:0])  * 64'(ub[63:32]);
      p10  <= 64'(ua[63:32]) * 64'(ub[31:0]);
      p11  <= 64'(ua[63:32]) * 64'(ub[63:32]);
      neg2 <= neg1;
      // sum and drop the fraction
      pr   <= full[FRAC_BITS+63:FRAC_BITS];
      neg3 <= neg2;
      // restore the sign
      p    <= neg3 ? 64'd0 - pr : pr;
    end
  end

endmodule

[rtl/gcs_isqrt.sv]
// Pipelined floor square root of v * 2^60, one result bit per register stage.
// Depends on gcs_pkg for widths.
module gcs_isqrt import gcs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_BITS-1:0] v,
  output logic [SQ_BITS-1:0] root
);

  localparam int W = 2 * SQ_BITS;

  logic [W-1:0]       rem_r  [1:SQ_BITS];
  logic [SQ_BITS-1:0] root_r [1:SQ_BITS];

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_step
    localparam int B = SQ_BITS - 1 - j;
    logic [W-1:0]       rem_i;
    logic [SQ_BITS-1:0] root_i;
    logic [W-1:0]       trial;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_i  = W'({v, {FRAC_BITS{1'b0}}});
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem_r[j];
      assign root_i = root_r[j];
    end

    // (r + 2^B)^2 - r^2
    assign trial = (W'(root_i) << (B + 1)) | (W'(1) << (2 * B));
    assign ge    = rem_i >= trial;

    // keep the bit when the trial fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? rem_i - trial : rem_i;
        root_r[j+1] <= root_i | (SQ_BITS'(ge) << B);
      end
    end
  end

  assign root = root_r[SQ_BITS];

endmodule

[rtl/gcs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gcs_pkg for widths.
module gcs_div import gcs_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [DIV_BITS-1:0] num,
  input  logic [SECS_W-1:0]   den,
  output logic [DIV_BITS-1:0] quo
);

  logic [SECS_W-1:0]   rem_r [1:DIV_BITS];
  logic [DIV_BITS-1:0] quo_r [1:DIV_BITS];
  logic [DIV_BITS-1:0] num_r [1:DIV_BITS];
  logic [SECS_W-1:0]   den_r [1:DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
    localparam int I = DIV_BITS - 1 - j;
    logic [SECS_W-1:0]   rem_i;
    logic [DIV_BITS-1:0] quo_i;
    logic [DIV_BITS-1:0] num_i;
    logic [SECS_W-1:0]   den_i;
    logic [SECS_W:0]     rs;
    logic                ge;

    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign quo_i = '0;
      assign num_i = num;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[j];
      assign quo_i = quo_r[j];
      assign num_i = num_r[j];
      assign den_i = den_r[j];
    end

    assign rs = {rem_i, num_i[I]};
    assign ge = rs >= {1'b0, den_i};

    // subtract when the divisor fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? SECS_W'(rs - {1'b0, den_i}) : rs[SECS_W-1:0];
        quo_r[j+1] <= quo_i | (DIV_BITS'(ge) << I);
        num_r[j+1] <= num_i;
        den_r[j+1] <= den_i;
      end
    end
  end

  assign quo = quo_r[DIV_BITS];

endmodule
